>>> design/tpws_pkg.sv
// Shared types, constants and tables of the trapezoidal waypoint sampler.
// Used by the interfaces, controller, datapath and top level; no dependencies.
package tpws_pkg;

  localparam int XYZ_W = 32;
  localparam int SPD_W = 23;
  localparam int PER_W = 17;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 23;
  localparam int ENG_W = 68;

  localparam logic [SPD_W-1:0] MAX_SPEED_RST = 23'd65536;
  localparam logic [SPD_W-1:0] MAX_ACCEL_RST = 23'd65536;
  localparam logic [PER_W-1:0] SAMPLE_PERIOD_RST = 17'd6554;

  localparam longint unsigned MAX_SEGMENT_SAMPLES = 65535;
  localparam logic [15:0] SAMPLE_CAP =
    16'((MAX_SEGMENT_SAMPLES > 65535) ? 65535 : MAX_SEGMENT_SAMPLES);

  // engine step counts
  localparam int MUL_STEPS = 34;
  localparam int DIV_STEPS = 66;
  localparam int SQRT_STEPS = 32;
  localparam int CORDIC_STEPS = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ACCEL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_PERIOD = 2'd2;

  typedef enum logic [1:0] {
    REQ_WAYPOINT = 2'd0,
    REQ_TICK     = 2'd1,
    REQ_FINISH   = 2'd2,
    REQ_NONE     = 2'd3
  } req_t;

  typedef enum logic [4:0] {
    OP_NONE, OP_LATCH, OP_WP_SHIFT, OP_SQX, OP_SQY, OP_LEN, OP_UX, OP_UY,
    OP_HEAD, OP_ACCD, OP_TSEL, OP_TSH_DIV, OP_TSH_SQRT, OP_TLG_A, OP_TLG_B,
    OP_CNT, OP_TK_A, OP_TK_B, OP_TK_X, OP_TK_Y, OP_TK_YS, OP_TK_ZMUL,
    OP_TK_ZDIV, OP_TK_EMIT, OP_FIN
  } dp_op_t;

  typedef enum logic [1:0] {
    ENG_MUL, ENG_DIV, ENG_SQRT, ENG_CORDIC
  } eng_mode_t;

  typedef enum logic [1:0] {
    ST_IDLE, ST_RUN, ST_WAIT
  } ctrl_state_t;

  typedef struct packed {
    dp_op_t op;
    logic   launch;
    logic   exec;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic out_free;
    logic seg_open;
    logic short_seg;
    logic samples_zero;
  } sts_t;

  function automatic logic op_is_iter(input dp_op_t op);
    logic r;
    unique case (op)
      OP_SQX, OP_SQY, OP_LEN, OP_UX, OP_UY, OP_HEAD, OP_ACCD, OP_TSH_DIV,
      OP_TSH_SQRT, OP_TLG_A, OP_TLG_B, OP_CNT, OP_TK_ZMUL, OP_TK_ZDIV: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic op_emits(input dp_op_t op);
    return (op == OP_TK_EMIT) || (op == OP_FIN);
  endfunction

  // arctangent of 2^-i in binary angle units
  function automatic logic [13:0] atan_lut(input logic [3:0] i);
    logic [13:0] r;
    unique case (i)
      4'd0: r = 14'd8192;
      4'd1: r = 14'd4836;
      4'd2: r = 14'd2555;
      4'd3: r = 14'd1297;
      4'd4: r = 14'd651;
      4'd5: r = 14'd326;
      4'd6: r = 14'd163;
      4'd7: r = 14'd81;
      4'd8: r = 14'd41;
      4'd9: r = 14'd20;
      4'd10: r = 14'd10;
      4'd11: r = 14'd5;
      4'd12: r = 14'd3;
      4'd13: r = 14'd1;
      4'd14: r = 14'd1;
      default: r = 14'd0;
    endcase
    return r;
  endfunction

endpackage

>>> design/tpws_if.sv
// Valid/ready channel interfaces for request items and sample result items.
// Depends on tpws_pkg for field widths.
interface tpws_in_if import tpws_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic signed [XYZ_W-1:0] wp_x;
  logic signed [XYZ_W-1:0] wp_y;
  logic signed [XYZ_W-1:0] wp_z;

  modport source (output valid, req_type, wp_x, wp_y, wp_z, input ready);
  modport sink (input valid, req_type, wp_x, wp_y, wp_z, output ready);
endinterface

interface tpws_out_if import tpws_pkg::*;;
  logic                    valid;
  logic                    ready;
  logic signed [XYZ_W-1:0] out_x;
  logic signed [XYZ_W-1:0] out_y;
  logic signed [XYZ_W-1:0] out_z;
  logic signed [15:0]      out_heading;
  logic [31:0]             out_time;
  logic                    segment_last;
  logic                    end_point;
  logic                    empty_error;

  modport source (output valid, out_x, out_y, out_z, out_heading, out_time,
                  segment_last, end_point, empty_error, input ready);
  modport sink (input valid, out_x, out_y, out_z, out_heading, out_time,
                segment_last, end_point, empty_error, output ready);
endinterface

>>> design/tpws_ctrl.sv
// Step sequencer of the sampler: accepts items and walks the datapath steps.
// Depends on tpws_pkg for command, status and step codes.
module tpws_ctrl import tpws_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_req_type,
  output logic       in_ready,
  output cmd_t       cmd,
  input  sts_t       sts
);

  ctrl_state_t state_r, state_nxt;
  dp_op_t      op_r, op_nxt;
  dp_op_t      step_next;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      op_r    <= OP_NONE;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
    end
  end

  always_comb begin
    unique case (op_r)
      OP_WP_SHIFT: step_next = sts.seg_open ? OP_SQX : OP_NONE;
      OP_SQX:      step_next = OP_SQY;
      OP_SQY:      step_next = OP_LEN;
      OP_LEN:      step_next = OP_UX;
      OP_UX:       step_next = OP_UY;
      OP_UY:       step_next = OP_HEAD;
      OP_HEAD:     step_next = OP_ACCD;
      OP_ACCD:     step_next = OP_TSEL;
      OP_TSEL:     step_next = sts.short_seg ? OP_TSH_DIV : OP_TLG_A;
      OP_TSH_DIV:  step_next = OP_TSH_SQRT;
      OP_TSH_SQRT: step_next = OP_CNT;
      OP_TLG_A:    step_next = OP_TLG_B;
      OP_TLG_B:    step_next = OP_CNT;
      OP_TK_A:     step_next = OP_TK_B;
      OP_TK_B:     step_next = OP_TK_X;
      OP_TK_X:     step_next = OP_TK_Y;
      OP_TK_Y:     step_next = OP_TK_YS;
      OP_TK_YS:    step_next = OP_TK_ZMUL;
      OP_TK_ZMUL:  step_next = OP_TK_ZDIV;
      OP_TK_ZDIV:  step_next = OP_TK_EMIT;
      default:     step_next = OP_NONE;
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    cmd.op     = OP_NONE;
    cmd.launch = 1'b0;
    cmd.exec   = 1'b0;
    in_ready   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op   = OP_LATCH;
          cmd.exec = 1'b1;
          unique case (req_t'(in_req_type))
            REQ_WAYPOINT: begin
              op_nxt    = OP_WP_SHIFT;
              state_nxt = ST_RUN;
            end
            REQ_TICK: begin
              // a tick with nothing left gives no item
              if (!sts.samples_zero) begin
                op_nxt    = OP_TK_A;
                state_nxt = ST_RUN;
              end
            end
            REQ_FINISH: begin
              op_nxt    = OP_FIN;
              state_nxt = ST_RUN;
            end
            REQ_NONE: ;
          endcase
        end
      end
      ST_RUN: begin
        cmd.op = op_r;
        if (op_is_iter(op_r)) begin
          cmd.launch = 1'b1;
          state_nxt  = ST_WAIT;
        end else if (!op_emits(op_r) || sts.out_free) begin
          cmd.exec  = 1'b1;
          op_nxt    = step_next;
          state_nxt = (step_next == OP_NONE) ? ST_IDLE : ST_RUN;
        end
      end
      ST_WAIT: begin
        cmd.op = op_r;
        if (!sts.busy) begin
          cmd.exec  = 1'b1;
          op_nxt    = step_next;
          state_nxt = (step_next == OP_NONE) ? ST_IDLE : ST_RUN;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  a_launch_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.launch |-> !sts.busy)
    else $error("engine launched while busy");

  a_launch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.launch |=> sts.busy)
    else $error("engine did not start after launch");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && (cmd.op == OP_TK_EMIT || cmd.op == OP_FIN)) |-> sts.out_free)
    else $error("result written over a pending item");

endmodule

>>> design/tpws_dp.sv
// Datapath of the sampler: config and segment state, shared iterative engine
// (multiply, divide, square root, CORDIC) and the output register. Uses tpws_pkg.
module tpws_dp import tpws_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  input  logic signed [XYZ_W-1:0] wp_x,
  input  logic signed [XYZ_W-1:0] wp_y,
  input  logic signed [XYZ_W-1:0] wp_z,
  output logic                    o_valid,
  input  logic                    o_ready,
  output logic signed [XYZ_W-1:0] o_x,
  output logic signed [XYZ_W-1:0] o_y,
  output logic signed [XYZ_W-1:0] o_z,
  output logic signed [15:0]      o_heading,
  output logic [31:0]             o_time,
  output logic                    o_last,
  output logic                    o_end,
  output logic                    o_empty
);

  // configuration
  logic [SPD_W-1:0] spd_r, acc_r;
  logic [PER_W-1:0] per_r;
  logic [SPD_W-1:0] v, a;
  logic [PER_W-1:0] dt;

  // segment state
  logic signed [XYZ_W-1:0] wx_r, wy_r, wz_r;
  logic signed [XYZ_W-1:0] sx_r, sy_r, sz_r, ex_r, ey_r, ez_r;
  logic signed [17:0] ux_r, uy_r;
  logic [15:0] heading_r, left_r;
  logic [31:0] len_r, dur_r, accd_r, along_r, traj_r, segclk_r;
  logic [SPD_W-1:0] speed_r;
  logic short_r;
  logic [1:0] pts_r;

  // scratch
  logic [65:0] sum_r;
  logic [47:0] tmp_r;
  logic [32:0] pos_r;
  logic [23:0] dv_r;
  logic [31:0] posc_r, x_r, y_r, z_r;
  logic signed [50:0] mul_r;

  // engine
  eng_mode_t mode_r, l_mode;
  logic busy_r;
  logic [6:0] cnt_r, l_cnt;
  logic [ENG_W-1:0] ea_r, eb_r, ec_r, l_ea, l_eb, l_ec, s_ea, s_eb, s_ec;

  // derived
  logic signed [32:0] dx, dy, dz;
  logic [32:0] adx, ady, adz;
  logic [45:0] vv;
  logic [39:0] spdt, adt;
  logic [33:0] fill;
  logic [31:0] skip_t, dsat, lm2d, posc_c;
  logic [49:0] tsum;
  logic [15:0] n_cnt;
  logic le_d, gt_l, tail, half, up, down;
  logic signed [25:0] sp;
  logic [SPD_W-1:0] sp_c;
  logic signed [35:0] cx0, cy0;
  logic signed [17:0] ang0;

  function automatic logic [31:0] sat_pos(input logic signed [31:0] s,
                                          input logic signed [50:0] m);
    logic signed [35:0] t;
    t = 36'(s) + 36'(m >>> 16);
    if (t > 36'sd2147483647) return 32'h7FFF_FFFF;
    else if (t < -36'sd2147483648) return 32'h8000_0000;
    else return t[31:0];
  endfunction

  assign v  = (spd_r == '0) ? SPD_W'(1) : spd_r;
  assign a  = (acc_r == '0) ? SPD_W'(1) : acc_r;
  assign dt = (per_r == '0) ? PER_W'(1) : per_r;

  assign dx  = 33'(ex_r) - 33'(sx_r);
  assign dy  = 33'(ey_r) - 33'(sy_r);
  assign dz  = 33'(ez_r) - 33'(sz_r);
  assign adx = dx[32] ? 33'(-dx) : 33'(dx);
  assign ady = dy[32] ? 33'(-dy) : 33'(dy);
  assign adz = dz[32] ? 33'(-dz) : 33'(dz);

  assign vv     = 46'(v) * 46'(v);
  assign spdt   = 40'(speed_r) * 40'(dt);
  assign adt    = 40'(a) * 40'(dt);
  assign fill   = (34'(left_r) + 34'd1) * 34'(dt);
  assign skip_t = traj_r + fill[31:0];
  assign dsat   = (ec_r[65:32] != '0) ? 32'hFFFF_FFFF : ec_r[31:0];
  assign lm2d   = 32'(33'(len_r) - {accd_r, 1'b0});
  assign tsum   = 50'({tmp_r, 1'b0}) + 50'(ec_r[48:0]);
  assign n_cnt  = (ec_r[65:16] != '0 || ec_r[15:0] > SAMPLE_CAP) ? SAMPLE_CAP : ec_r[15:0];

  // accelerate / cruise / decelerate decision
  assign le_d   = pos_r <= {1'b0, accd_r};
  assign gt_l   = pos_r > {1'b0, len_r};
  assign tail   = gt_l || (({1'b0, len_r} - pos_r) <= {1'b0, accd_r});
  assign half   = {1'b0, segclk_r, 1'b0} < {2'b0, dur_r};
  assign up     = short_r ? half : le_d;
  assign down   = short_r ? !half : (!le_d && tail);
  assign sp     = up ? (26'(speed_r) + 26'(dv_r)) :
                  down ? (26'(speed_r) - 26'(dv_r)) : 26'(speed_r);
  assign sp_c   = (sp < 0) ? '0 : (sp > $signed(26'(v))) ? v : sp[SPD_W-1:0];
  assign posc_c = gt_l ? len_r : pos_r[31:0];

  // CORDIC entry: scale by 2^14 and fold into the right half plane
  always_comb begin
    cx0 = {{4{ux_r[17]}}, ux_r, 14'b0};
    cy0 = {{4{uy_r[17]}}, uy_r, 14'b0};
    ang0 = '0;
    if (cx0 < 0) begin
      if (cy0 >= 0) begin
        cx0  = {{4{uy_r[17]}}, uy_r, 14'b0};
        cy0  = -{{4{ux_r[17]}}, ux_r, 14'b0};
        ang0 = 18'sd16384;
      end else begin
        cx0  = -{{4{uy_r[17]}}, uy_r, 14'b0};
        cy0  = {{4{ux_r[17]}}, ux_r, 14'b0};
        ang0 = -18'sd16384;
      end
    end
  end

  // engine operand selection
  always_comb begin
    l_mode = ENG_DIV;
    l_cnt  = 7'(DIV_STEPS - 1);
    l_ea   = '0;
    l_eb   = '0;
    l_ec   = '0;
    unique case (cmd.op)
      OP_SQX, OP_SQY, OP_TK_ZMUL: begin
        l_mode = ENG_MUL;
        l_cnt  = 7'(MUL_STEPS - 1);
        l_ea   = (cmd.op == OP_SQX) ? ENG_W'(adx) : (cmd.op == OP_SQY) ? ENG_W'(ady) : ENG_W'(adz);
        l_eb   = (cmd.op == OP_SQX) ? ENG_W'(adx) : (cmd.op == OP_SQY) ? ENG_W'(ady) : ENG_W'(posc_r);
      end
      OP_LEN, OP_TSH_SQRT: begin
        l_mode = ENG_SQRT;
        l_cnt  = 7'(SQRT_STEPS - 1);
        l_ea   = (cmd.op == OP_LEN) ? ENG_W'(sum_r[63:0]) : ENG_W'({tmp_r, 16'b0});
        l_ec   = ENG_W'(64'h4000_0000_0000_0000);
      end
      OP_HEAD: begin
        l_mode = ENG_CORDIC;
        l_cnt  = 7'(CORDIC_STEPS - 1);
        l_ea   = ENG_W'(cx0);
        l_eb   = ENG_W'(cy0);
        l_ec   = ENG_W'(ang0);
      end
      OP_UX:      begin l_eb = ENG_W'(len_r);         l_ec = ENG_W'({adx, 16'b0}); end
      OP_UY:      begin l_eb = ENG_W'(len_r);         l_ec = ENG_W'({ady, 16'b0}); end
      OP_ACCD:    begin l_eb = ENG_W'({a, 1'b0});     l_ec = ENG_W'(vv); end
      OP_TSH_DIV: begin l_eb = ENG_W'(a);             l_ec = ENG_W'({len_r, 16'b0}); end
      OP_TLG_A:   begin l_eb = ENG_W'(a);             l_ec = ENG_W'({v, 16'b0}); end
      OP_TLG_B:   begin l_eb = ENG_W'(v);             l_ec = ENG_W'({lm2d, 16'b0}); end
      OP_CNT:     begin l_eb = ENG_W'(dt);            l_ec = ENG_W'(dur_r); end
      OP_TK_ZDIV: begin l_eb = ENG_W'(len_r);         l_ec = ENG_W'(sum_r); end
      default: ;
    endcase
  end

  // one engine step
  always_comb begin
    logic [35:0] dtrial;
    logic [64:0] ssum;
    logic signed [35:0] cx, cy, cxs, cys;
    logic signed [17:0] cang, ctab;
    logic [3:0] ci;
    s_ea = ea_r;
    s_eb = eb_r;
    s_ec = ec_r;
    dtrial = {1'b0, ea_r[33:0], ec_r[65]} - {2'b0, eb_r[33:0]};
    ssum = 65'(eb_r[63:0]) + 65'(ec_r[63:0]);
    cx = ea_r[35:0];
    cy = eb_r[35:0];
    ci = 4'(7'(CORDIC_STEPS - 1) - cnt_r);
    cxs = cx >>> ci;
    cys = cy >>> ci;
    cang = ec_r[17:0];
    ctab = $signed({4'b0, atan_lut(ci)});
    unique case (mode_r)
      ENG_MUL: begin
        s_ec = ec_r + (eb_r[0] ? ea_r : '0);
        s_ea = ea_r << 1;
        s_eb = eb_r >> 1;
      end
      ENG_DIV: begin
        if (!dtrial[35]) begin
          s_ea = ENG_W'(dtrial[34:0]);
          s_ec = ENG_W'({ec_r[64:0], 1'b1});
        end else begin
          s_ea = ENG_W'({ea_r[33:0], ec_r[65]});
          s_ec = ENG_W'({ec_r[64:0], 1'b0});
        end
      end
      ENG_SQRT: begin
        if ({1'b0, ea_r[63:0]} >= ssum) begin
          s_ea = ENG_W'({1'b0, ea_r[63:0]} - ssum);
          s_eb = ENG_W'((eb_r[63:0] >> 1) + ec_r[63:0]);
        end else begin
          s_eb = eb_r >> 1;
        end
        s_ec = ec_r >> 2;
      end
      ENG_CORDIC: begin
        if (cy > 0) begin
          s_ea = ENG_W'(cx + cys);
          s_eb = ENG_W'(cy - cxs);
          s_ec = ENG_W'(cang + ctab);
        end else begin
          s_ea = ENG_W'(cx - cys);
          s_eb = ENG_W'(cy + cxs);
          s_ec = ENG_W'(cang - ctab);
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (cmd.launch) begin
      busy_r <= 1'b1;
    end else if (busy_r && cnt_r == '0) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= ENG_MUL;
    end else if (cmd.launch) begin
      mode_r <= l_mode;
      cnt_r  <= l_cnt;
      ea_r   <= l_ea;
      eb_r   <= l_eb;
      ec_r   <= l_ec;
    end else if (busy_r) begin
      cnt_r <= cnt_r - 7'd1;
      ea_r  <= s_ea;
      eb_r  <= s_eb;
      ec_r  <= s_ec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_r <= MAX_SPEED_RST;
      acc_r <= MAX_ACCEL_RST;
      per_r <= SAMPLE_PERIOD_RST;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MAX_SPEED) spd_r <= cfg_data;
      if (cfg_index == CFG_MAX_ACCEL) acc_r <= cfg_data;
      if (cfg_index == CFG_SAMPLE_PERIOD) per_r <= cfg_data[PER_W-1:0];
    end
  end

  // trajectory state; a finish clears it after its item is formed
  always_ff @(posedge clk) begin
    if (!rst_n || (cmd.exec && cmd.op == OP_FIN)) begin
      sx_r <= '0; sy_r <= '0; sz_r <= '0;
      ex_r <= '0; ey_r <= '0; ez_r <= '0;
      ux_r <= '0; uy_r <= '0;
      heading_r <= '0; len_r <= '0; dur_r <= '0; accd_r <= '0;
      short_r <= 1'b0; left_r <= '0; along_r <= '0; speed_r <= '0;
      traj_r <= '0; segclk_r <= '0; pts_r <= '0;
    end else if (cmd.exec) begin
      unique case (cmd.op)
        OP_WP_SHIFT: begin
          if (left_r != '0) traj_r <= skip_t;
          left_r <= '0;
          sx_r <= (pts_r == '0) ? wx_r : ex_r;
          sy_r <= (pts_r == '0) ? wy_r : ey_r;
          sz_r <= (pts_r == '0) ? wz_r : ez_r;
          ex_r <= wx_r;
          ey_r <= wy_r;
          ez_r <= wz_r;
          pts_r <= (pts_r == '0) ? 2'd1 : 2'd2;
        end
        OP_LEN:  len_r <= (sum_r[65:64] != '0) ? 32'hFFFF_FFFF : eb_r[31:0];
        OP_UX:   ux_r <= (len_r == '0) ? '0 : dx[32] ? -$signed(ec_r[17:0]) : $signed(ec_r[17:0]);
        OP_UY:   uy_r <= (len_r == '0) ? '0 : dy[32] ? -$signed(ec_r[17:0]) : $signed(ec_r[17:0]);
        OP_HEAD: heading_r <= (ux_r == '0 && uy_r == '0) ? '0 : ec_r[15:0];
        OP_ACCD: begin
          accd_r  <= dsat;
          short_r <= {1'b0, len_r} < {dsat, 1'b0};
        end
        OP_TSH_SQRT: dur_r <= eb_r[31] ? 32'hFFFF_FFFF : {eb_r[30:0], 1'b0};
        OP_TLG_B:    dur_r <= (tsum[49:32] != '0) ? 32'hFFFF_FFFF : tsum[31:0];
        OP_CNT: begin
          left_r   <= n_cnt;
          along_r  <= '0;
          segclk_r <= '0;
          if (n_cnt == '0) traj_r <= traj_r + 32'(dt);
        end
        OP_TK_B: begin
          speed_r <= sp_c;
          along_r <= posc_c;
        end
        OP_TK_EMIT: begin
          traj_r   <= traj_r + 32'(dt) + ((left_r == 16'd1) ? 32'(dt) : 32'd0);
          segclk_r <= segclk_r + 32'(dt);
          left_r   <= left_r - 16'd1;
        end
        default: ;
      endcase
    end
  end

  // working registers, no reset needed
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      unique case (cmd.op)
        OP_LATCH: begin
          wx_r <= wp_x;
          wy_r <= wp_y;
          wz_r <= wp_z;
        end
        OP_SQX:      sum_r <= ec_r[65:0];
        OP_SQY:      sum_r <= sum_r + ec_r[65:0];
        OP_TSH_DIV:  tmp_r <= ec_r[47:0];
        OP_TLG_A:    tmp_r <= ec_r[47:0];
        OP_TK_A: begin
          pos_r <= 33'(along_r) + 33'(spdt[39:16]);
          dv_r  <= adt[39:16];
        end
        OP_TK_B:     posc_r <= posc_c;
        OP_TK_X:     mul_r <= ux_r * $signed({1'b0, posc_r});
        OP_TK_Y: begin
          x_r   <= sat_pos(sx_r, mul_r);
          mul_r <= uy_r * $signed({1'b0, posc_r});
        end
        OP_TK_YS:    y_r <= sat_pos(sy_r, mul_r);
        OP_TK_ZMUL:  sum_r <= ec_r[65:0];
        OP_TK_ZDIV:  z_r <= (len_r == '0) ? sz_r :
                            dz[32] ? sz_r - ec_r[31:0] : sz_r + ec_r[31:0];
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid <= 1'b0;
    end else if (cmd.exec && op_emits(cmd.op)) begin
      o_valid <= 1'b1;
    end else if (o_ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && cmd.op == OP_TK_EMIT) begin
      o_x       <= x_r;
      o_y       <= y_r;
      o_z       <= z_r;
      o_heading <= heading_r;
      o_time    <= traj_r;
      o_last    <= left_r == 16'd1;
      o_end     <= 1'b0;
      o_empty   <= 1'b0;
    end else if (cmd.exec && cmd.op == OP_FIN) begin
      o_x       <= (pts_r == '0) ? '0 : ex_r;
      o_y       <= (pts_r == '0) ? '0 : ey_r;
      o_z       <= (pts_r == '0) ? '0 : ez_r;
      o_heading <= (pts_r == 2'd2) ? heading_r : '0;
      o_time    <= (pts_r == '0) ? '0 : (left_r != '0) ? skip_t : traj_r;
      o_last    <= 1'b0;
      o_end     <= pts_r != '0;
      o_empty   <= pts_r == '0;
    end
  end

  assign sts.busy         = busy_r;
  assign sts.out_free     = !o_valid || o_ready;
  assign sts.seg_open     = pts_r != '0;
  assign sts.short_seg    = short_r;
  assign sts.samples_zero = left_r == '0;

endmodule

>>> design/trapezoidal_profile_waypoint_sampler.sv
// Trapezoidal profile waypoint sampler, top level. Uses tpws_pkg, tpws_if.
// One item at a time. A tick uses the shared engine for one 34-step
// multiply and one 66-step divide for z; a waypoint that opens a segment
// (triangular or trapezoidal) uses squares, root, divides and CORDIC.
// Finish and first waypoint use no engine. Result goes through an output register.
// Sync active-low reset clears control and trajectory state, sets config defaults.
module trapezoidal_profile_waypoint_sampler import tpws_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  tpws_in_if.sink               in_ch,
  tpws_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  tpws_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .cmd         (cmd),
    .sts         (sts)
  );

  tpws_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .wp_x      (in_ch.wp_x),
    .wp_y      (in_ch.wp_y),
    .wp_z      (in_ch.wp_z),
    .o_valid   (out_ch.valid),
    .o_ready   (out_ch.ready),
    .o_x       (out_ch.out_x),
    .o_y       (out_ch.out_y),
    .o_z       (out_ch.out_z),
    .o_heading (out_ch.out_heading),
    .o_time    (out_ch.out_time),
    .o_last    (out_ch.segment_last),
    .o_end     (out_ch.end_point),
    .o_empty   (out_ch.empty_error)
  );

endmodule
